/* rtl/core/dls_pkg.sv */
// Shared constants, types and lane helpers for the RGB565 dark level subtraction block.
`default_nettype none

package dls_pkg;

   localparam int LANES     = 3;
   localparam int LANE_W    = 16;
   localparam int CSR_W     = LANES * LANE_W;
   localparam int CSR_IDX_W = 3;
   localparam int PIX_W     = 16;
   localparam int CHAN_W    = 8;
   localparam int DIV_STEPS = CHAN_W;
   localparam int REM_W     = LANE_W + CHAN_W;

   // Four arithmetic stages and the divider stages ahead of the output register.
   localparam int PIPE_DEPTH = 4 + DIV_STEPS + 1;
   localparam int LATENCY    = PIPE_DEPTH + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POST_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POST_BIAS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DARK      = 3'd4;

   localparam logic [CSR_W-1:0] GAIN_RESET = 48'h1000_1000_1000;
   localparam logic [CSR_W-1:0] ZERO_RESET = '0;

   localparam logic [CHAN_W-1:0] RED_MASK      = 8'hf8;
   localparam logic [CHAN_W-1:0] GREEN_LO_MASK = 8'he0;
   localparam logic [CHAN_W-1:0] CHAN_MAX      = 8'hff;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [CHAN_W-1:0] quo;
      logic              force_zero;
      logic              force_max;
   } div_lane_type;

   // Lane 0 is red in the top bits, lane 2 is blue in the bottom bits.
   function automatic logic [LANE_W-1:0] lane_of(input logic [CSR_W-1:0] word, input int ch);
      lane_of = word[(LANES-1-ch)*LANE_W +: LANE_W];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/rgb565_dark_level_subtract.sv */
// Top level of the RGB565 dark level subtraction pipeline.
//
// A pixel word is taken at each rising edge at which start is high and busy is low; busy
// stays low, so one word can be taken in every cycle. The red, green and blue channels are
// corrected side by side: gain and bias, dark level clamp, post gain and post bias, then an
// eight step restoring divide by the channel gain, one quotient bit per register stage.
// The result word appears on rsp_pixel_out and rsp_last_out with rsp_valid high for one
// cycle and is taken at the edge that ends that cycle. Throughput is one word per cycle;
// the depth is set by the divider stages.
// The receiver cannot stall the block, so no word is ever held back.
// Registers are written through csr_we, csr_index and csr_wdata while no word is in flight,
// which the user must ensure, as the block does not; an index beyond the list is ignored.
// Reset empties the pipeline and returns the gains to one and all offsets to zero.
`default_nettype none

module rgb565_dark_level_subtract (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [dls_pkg::PIX_W-1:0]     req_pixel_in,
   input  wire logic                          req_last_pixel,
   output logic                               rsp_valid,
   output logic [dls_pkg::PIX_W-1:0]          rsp_pixel_out,
   output logic                               rsp_last_out,
   input  wire logic                          csr_we,
   input  wire logic [dls_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [dls_pkg::CSR_W-1:0]     csr_wdata
);
   import dls_pkg::*;

   logic [CSR_W-1:0] gain_ff, gain_in;
   logic [CSR_W-1:0] bias_ff, bias_in;
   logic [CSR_W-1:0] post_gain_ff, post_gain_in;
   logic [CSR_W-1:0] post_bias_ff, post_bias_in;
   logic [CSR_W-1:0] dark_ff, dark_in;

   logic vld_ff  [0:PIPE_DEPTH-1];
   logic vld_in  [0:PIPE_DEPTH-1];
   logic last_ff [0:PIPE_DEPTH-1];
   logic last_in [0:PIPE_DEPTH-1];

   logic [CHAN_W-1:0]        chan      [0:LANES-1];
   logic [CHAN_W-1:0]        green_lo;
   logic [2*LANE_W-8-1:0]    s1_prod_ff [0:LANES-1];
   logic [2*LANE_W-8-1:0]    s1_prod_in [0:LANES-1];
   logic [2*LANE_W-1:0]      s1_pbg_ff  [0:LANES-1];
   logic [2*LANE_W-1:0]      s1_pbg_in  [0:LANES-1];
   logic [REM_W+1:0]         s2_w_ff    [0:LANES-1];
   logic [REM_W+1:0]         s2_w_in    [0:LANES-1];
   logic [2*LANE_W-1:0]      s2_pbg_ff  [0:LANES-1];
   logic [REM_W+LANE_W+2:0]  s3_wpg_ff  [0:LANES-1];
   logic [REM_W+LANE_W+2:0]  s3_wpg_in  [0:LANES-1];
   logic [2*LANE_W-1:0]      s3_pbg_ff  [0:LANES-1];
   logic [CSR_W-1:0]         s4_num_ff  [0:LANES-1];
   logic [CSR_W-1:0]         s4_num_in  [0:LANES-1];
   div_lane_type             div_ff     [0:DIV_STEPS][0:LANES-1];
   div_lane_type             div_in     [0:DIV_STEPS][0:LANES-1];
   logic [CHAN_W-1:0]        res        [0:LANES-1];

   logic                     rsp_valid_ff, rsp_last_ff;
   logic [PIX_W-1:0]         rsp_pixel_ff, rsp_pixel_in;

   assign busy = 1'b0;

   // Register file.
   always_comb begin
      gain_in      = gain_ff;
      bias_in      = bias_ff;
      post_gain_in = post_gain_ff;
      post_bias_in = post_bias_ff;
      dark_in      = dark_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN:      gain_in      = csr_wdata;
            CSR_BIAS:      bias_in      = csr_wdata;
            CSR_POST_GAIN: post_gain_in = csr_wdata;
            CSR_POST_BIAS: post_bias_in = csr_wdata;
            CSR_DARK:      dark_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         bias_ff      <= ZERO_RESET;
         post_gain_ff <= GAIN_RESET;
         post_bias_ff <= ZERO_RESET;
         dark_ff      <= ZERO_RESET;
      end else begin
         gain_ff      <= gain_in;
         bias_ff      <= bias_in;
         post_gain_ff <= post_gain_in;
         post_bias_ff <= post_bias_in;
         dark_ff      <= dark_in;
      end
   end

   // Valid and last flags travel alongside the word.
   always_comb begin
      vld_in[0]  = start & ~busy;
      last_in[0] = req_last_pixel;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
         vld_in[i]  = vld_ff[i-1];
         last_in[i] = last_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < PIPE_DEPTH; i++) begin
            vld_ff[i] <= vld_in[i];
         end
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   // Stage one: unpack and form pixel times gain and post bias times gain.
   always_comb begin
      logic [LANE_W-1:0] pb;
      green_lo = (req_pixel_in[7:0] & GREEN_LO_MASK) >> 3;
      chan[0]  = req_pixel_in[15:8] & RED_MASK;
      chan[1]  = {req_pixel_in[10:8], green_lo[4:0]};
      chan[2]  = {req_pixel_in[4:0], 3'b000};
      for (int l = 0; l < LANES; l++) begin
         pb            = lane_of(post_bias_ff, l);
         s1_prod_in[l] = {16'b0, chan[l]} * {8'b0, lane_of(gain_ff, l)};
         s1_pbg_in[l]  = $signed({{16{pb[LANE_W-1]}}, pb})
                       * $signed({16'b0, lane_of(gain_ff, l)});
      end
   end

   // Stage two: dark level clamp; the difference is taken against the dark level.
   always_comb begin
      logic [REM_W-1:0] b24;
      logic [REM_W+1:0] bext, pext, dext, sum;
      logic             clamp;
      for (int l = 0; l < LANES; l++) begin
         b24   = {lane_of(bias_ff, l), 8'b0};
         bext  = {{2{b24[REM_W-1]}}, b24};
         pext  = {2'b0, s1_prod_ff[l]};
         dext  = {2'b0, lane_of(dark_ff, l), 8'b0};
         sum   = pext + bext;
         clamp = $signed(dext) > $signed(sum);
         s2_w_in[l] = clamp ? (~bext + 1'b1) : (pext - dext);
      end
   end

   // Stage three: difference times post gain.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         s3_wpg_in[l] = $signed({{17{s2_w_ff[l][REM_W+1]}}, s2_w_ff[l]})
                      * $signed({27'b0, lane_of(post_gain_ff, l)});
      end
   end

   // Stage four: full numerator in units of 2^-16 of the gain scaled divisor.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         s4_num_in[l] = {s3_wpg_ff[l][REM_W+LANE_W+2], s3_wpg_ff[l], 4'b0}
                      + {{4{s3_pbg_ff[l][2*LANE_W-1]}}, s3_pbg_ff[l], 12'b0};
      end
   end

   // Divider entry and one restoring step per stage after it.
   always_comb begin
      logic [30:0]      nq;
      logic             fz;
      logic [REM_W-1:0] dv;
      for (int l = 0; l < LANES; l++) begin
         nq = s4_num_ff[l][46:16];
         fz = s4_num_ff[l][CSR_W-1] | (lane_of(gain_ff, l) == '0);
         div_in[0][l].rem        = nq[REM_W-1:0];
         div_in[0][l].quo        = '0;
         div_in[0][l].force_zero = fz;
         div_in[0][l].force_max  = ~fz & (nq >= {7'b0, lane_of(gain_ff, l), 8'b0});
      end
      for (int s = 1; s <= DIV_STEPS; s++) begin
         for (int l = 0; l < LANES; l++) begin
            dv = {8'b0, lane_of(gain_ff, l)} << (DIV_STEPS - s);
            div_in[s][l] = div_ff[s-1][l];
            if (div_ff[s-1][l].rem >= dv) begin
               div_in[s][l].rem = div_ff[s-1][l].rem - dv;
               div_in[s][l].quo[DIV_STEPS-s] = 1'b1;
            end
         end
      end
   end

   // Saturation and repacking.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (div_ff[DIV_STEPS][l].force_zero) begin
            res[l] = '0;
         end else if (div_ff[DIV_STEPS][l].force_max) begin
            res[l] = CHAN_MAX;
         end else begin
            res[l] = div_ff[DIV_STEPS][l].quo;
         end
      end
      rsp_pixel_in = {res[0][7:3], res[1][7:2], res[2][7:3]};
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
         last_ff[i] <= last_in[i];
      end
      for (int l = 0; l < LANES; l++) begin
         s1_prod_ff[l] <= s1_prod_in[l];
         s1_pbg_ff[l]  <= s1_pbg_in[l];
         s2_w_ff[l]    <= s2_w_in[l];
         s2_pbg_ff[l]  <= s1_pbg_ff[l];
         s3_wpg_ff[l]  <= s3_wpg_in[l];
         s3_pbg_ff[l]  <= s2_pbg_ff[l];
         s4_num_ff[l]  <= s4_num_in[l];
      end
      for (int s = 0; s <= DIV_STEPS; s++) begin
         for (int l = 0; l < LANES; l++) begin
            div_ff[s][l] <= div_in[s][l];
         end
      end
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= last_ff[PIPE_DEPTH-1];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_last_out  = rsp_last_ff;

   // A result word is only ever the image of a word taken a fixed latency earlier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("Result word without a matching input word.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_out == $past(req_last_pixel, LATENCY))
      else $error("Last flag does not follow its word.");

   // Once all quotient bits are settled the remainder lies below the gain.
   for (genvar l = 0; l < LANES; l++) begin : g_div_chk
      assert property (@(posedge clock) disable iff (reset)
         vld_ff[PIPE_DEPTH-1] && !div_ff[DIV_STEPS][l].force_zero
            && !div_ff[DIV_STEPS][l].force_max
         |-> div_ff[DIV_STEPS][l].rem < {8'b0, lane_of(gain_ff, l)})
         else $error("Divider remainder not below the gain.");
   end

endmodule

`default_nettype wire

/* sim/dls_checker.sv */
// Checker that predicts and compares every corrected pixel word of the dark level block.
module dls_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          busy,
   input  wire logic [dls_pkg::PIX_W-1:0]     req_pixel_in,
   input  wire logic                          req_last_pixel,
   input  wire logic                          rsp_valid,
   input  wire logic [dls_pkg::PIX_W-1:0]     rsp_pixel_out,
   input  wire logic                          rsp_last_out,
   input  wire logic                          csr_we,
   input  wire logic [dls_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [dls_pkg::CSR_W-1:0]     csr_wdata,
   output int                                 mismatch_count,
   output int                                 pending_words,
   output int                                 checked_words
);
   timeunit 1ns;
   timeprecision 1ps;

   import dls_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } pixel_word_type;

   logic [CSR_W-1:0] gain_set, bias_set, post_gain_set, post_bias_set, dark_set;
   pixel_word_type   expected_pixels[$];
   int               errors  = 0;
   int               checked = 0;

   function automatic logic [CHAN_W-1:0] corrected_level(input logic [CHAN_W-1:0] level,
                                                         input int lane);
      int     base;
      longint gain, bias, post_gain, post_bias, dark, v, quotient;
      base      = (LANES - 1 - lane) * LANE_W;
      gain      = longint'(gain_set[base +: LANE_W]);
      bias      = longint'($signed(bias_set[base +: LANE_W])) * 256;
      post_gain = longint'(post_gain_set[base +: LANE_W]);
      post_bias = longint'($signed(post_bias_set[base +: LANE_W]));
      dark      = longint'(dark_set[base +: LANE_W]) * 256;
      if (gain == 0)
         return '0;
      v = longint'(level) * gain + bias;
      if (dark > v)
         v = 0;
      else
         v = v - dark;
      quotient = ((v - bias) * post_gain * 16 + post_bias * gain * 4096) / (gain * 65536);
      if (quotient < 0)
         return '0;
      if (quotient > 255)
         return CHAN_MAX;
      return quotient[CHAN_W-1:0];
   endfunction

   function automatic pixel_word_type dark_corrected(input logic [PIX_W-1:0] pixel,
                                                     input logic last);
      logic [CHAN_W-1:0] red, green, blue;
      red   = corrected_level({pixel[15:11], 3'b000}, 0);
      green = corrected_level({pixel[10:5], 2'b00}, 1);
      blue  = corrected_level({pixel[4:0], 3'b000}, 2);
      return '{pixel: {red[7:3], green[7:2], blue[7:3]}, last: last};
   endfunction

   always @(posedge clock) begin : monitor
      pixel_word_type want;
      if (reset) begin
         gain_set      = GAIN_RESET;
         bias_set      = ZERO_RESET;
         post_gain_set = GAIN_RESET;
         post_bias_set = ZERO_RESET;
         dark_set      = ZERO_RESET;
         expected_pixels.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (expected_pixels.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected word pixel=%h last=%b", $realtime, rsp_pixel_out,
                           rsp_last_out);
            end else begin
               want = expected_pixels.pop_front();
               checked++;
               if (rsp_pixel_out !== want.pixel || rsp_last_out !== want.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch, expected pixel=%h last=%b, got pixel=%h last=%b",
                              $realtime, want.pixel, want.last, rsp_pixel_out, rsp_last_out);
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            expected_pixels.push_back(dark_corrected(req_pixel_in, req_last_pixel));
         if (csr_we === 1'b1) begin
            case (csr_index)
               CSR_GAIN:      gain_set      = csr_wdata;
               CSR_BIAS:      bias_set      = csr_wdata;
               CSR_POST_GAIN: post_gain_set = csr_wdata;
               CSR_POST_BIAS: post_bias_set = csr_wdata;
               CSR_DARK:      dark_set      = csr_wdata;
               default:       ;
            endcase
         end
      end
      mismatch_count <= errors;
      pending_words  <= expected_pixels.size();
      checked_words  <= checked;
   end

endmodule

/* sim/tb_top.sv */
// Testbench top for the dark level subtraction block: clock, reset, stimulus and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dls_pkg::*;

   typedef enum {UNSIGNED_GAIN, SIGNED_OFFSET, DARK_LEVEL} lane_kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_FIRST = 3'd5;
   localparam int RANDOM_PHASES   = 8;
   localparam int WORDS_PER_PHASE = 230;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [PIX_W-1:0]     req_pixel_in;
   logic                 req_last_pixel;
   logic                 rsp_valid;
   logic [PIX_W-1:0]     rsp_pixel_out;
   logic                 rsp_last_out;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   int                   mismatch_count;
   int                   pending_words;
   int                   checked_words;
   int                   words_sent      = 0;
   int                   settings_loaded = 0;

   rgb565_dark_level_subtract dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pixel_in   (req_pixel_in),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_last_out   (rsp_last_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   dls_checker dls_chk (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pixel_in   (req_pixel_in),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_last_out   (rsp_last_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_words  (pending_words),
      .checked_words  (checked_words)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic logic [LANE_W-1:0] random_lane(input lane_kind_type kind);
      case ($urandom_range(9))
         0: random_lane = (kind == SIGNED_OFFSET) ? 16'h8000 : 16'h0000;
         1: random_lane = (kind == SIGNED_OFFSET) ? 16'h7fff : 16'hffff;
         2: random_lane = 16'($urandom);
         default: begin
            case (kind)
               UNSIGNED_GAIN: random_lane = 16'($urandom_range(16'h2400, 16'h0600));
               SIGNED_OFFSET: random_lane = 16'($urandom_range(16'h0800) - 16'h0400);
               default:       random_lane = 16'($urandom_range(16'h0c00));
            endcase
         end
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] random_triple(input lane_kind_type kind);
      return {random_lane(kind), random_lane(kind), random_lane(kind)};
   endfunction

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [CSR_W-1:0] gain, input logic [CSR_W-1:0] bias,
                                input logic [CSR_W-1:0] post_gain,
                                input logic [CSR_W-1:0] post_bias,
                                input logic [CSR_W-1:0] dark);
      write_register(CSR_GAIN, gain);
      write_register(CSR_BIAS, bias);
      write_register(CSR_POST_GAIN, post_gain);
      write_register(CSR_POST_BIAS, post_bias);
      write_register(CSR_DARK, dark);
      // Writes beyond the register list must leave the settings alone.
      write_register(CSR_IDX_W'(CSR_UNUSED_FIRST + $urandom_range(2)),
                     {16'($urandom), 32'($urandom)});
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] pixel, input logic last);
      start          <= 1'b1;
      req_pixel_in   <= pixel;
      req_last_pixel <= last;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      words_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_words != 0)
         @(posedge clock);
   endtask

   initial begin : stimulus
      logic [PIX_W-1:0] directed_pixels[7];
      int               idle_pct[4];
      int               idle;
      logic [PIX_W-1:0] pixel;

      directed_pixels = '{16'h0000, 16'hffff, 16'hf800, 16'h07e0, 16'h001f, 16'ha5a5, 16'h5a5a};
      idle_pct        = '{0, 77, 0, 7};
      reset          = 1'b1;
      start          = 1'b0;
      req_pixel_in   = '0;
      req_last_pixel = 1'b0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings give unity gains and zero offsets, so each pixel word comes back unchanged.
      foreach (directed_pixels[i])
         send_pixel(directed_pixels[i], i[0]);
      drain();

      // Zero red gain, negative green bias under a small dark level, full blue dark level.
      load_settings(48'h0000_ffff_1000, 48'h7fff_8000_0000, 48'hffff_0000_4000,
                    48'h7fff_8000_0010, 48'h0000_0010_ffff);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hffff, 1'b1);
      send_pixel(16'h8410, 1'b0);
      send_pixel(16'h7bef, 1'b1);
      drain();

      // Clamped channels with post offsets that push results below zero and within range.
      load_settings(48'h1000_1000_1000, 48'h8000_8000_8000, 48'h0100_0100_0100,
                    48'h8000_0000_ff00, 48'h0001_0001_0001);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hffff, 1'b1);
      send_pixel(16'h4208, 1'b0);
      send_pixel(16'hbdf7, 1'b1);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0)
            load_settings('1, '1, '1, '1, '1);
         else if (phase == 1)
            load_settings('0, '0, '0, '0, '0);
         else
            load_settings(random_triple(UNSIGNED_GAIN), random_triple(SIGNED_OFFSET),
                          random_triple(UNSIGNED_GAIN), random_triple(SIGNED_OFFSET),
                          random_triple(DARK_LEVEL));
         idle = idle_pct[phase % 4];
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            case ($urandom_range(7))
               0:       pixel = 16'h0000;
               1:       pixel = 16'hffff;
               default: pixel = 16'($urandom);
            endcase
            send_pixel(pixel, $urandom_range(15) == 0);
            if ($urandom_range(99) < idle) begin
               start <= 1'b0;
               do
                  @(posedge clock);
               while ($urandom_range(99) < idle);
            end
         end
         drain();
      end

      repeat (LATENCY + 4) @(posedge clock);
      $display("Run covered %0d pixel words under %0d register settings, %0d results compared.",
               words_sent, settings_loaded + 1, checked_words);
      $display("Sender idling ran at 0, 7 and 77 percent; every register took extreme values.");
      if (mismatch_count == 0 && pending_words == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
